// File: hw/rtl/host_buffer_access_splitter_assert.svh
// Assertion macros used by the checker file of the host buffer access splitter.
`ifndef HOST_BUFFER_ACCESS_SPLITTER_ASSERT_SVH
`define HOST_BUFFER_ACCESS_SPLITTER_ASSERT_SVH

// Checked outside reset.
`define HBAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define HBAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/hbas_pkg.sv
// Shared types and constants of the host buffer access splitter.
package hbas_pkg;

  localparam int unsigned MAX_DESCRIPTORS = 32;
  localparam int unsigned DESC_IW = $clog2(MAX_DESCRIPTORS);
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PW = $clog2(QUEUE_DEPTH);

  localparam int unsigned BASE_W = 64;
  localparam int unsigned PAGES_W = 32;
  localparam int unsigned PAGE_BYTES_W = 28;
  localparam int unsigned TOTAL_W = 49;
  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned SEG_W = PAGES_W + PAGE_BYTES_W;
  localparam int unsigned CFG_DW = TOTAL_W;

  localparam logic [1:0] CFG_ENABLED = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_PAGE_BYTES = 2'd2;
  localparam logic [1:0] CFG_TOTAL = 2'd3;

  localparam logic CMD_LOAD = 1'b0;

  typedef enum logic [1:0] {
    KIND_CHUNK = 2'd0,
    KIND_DONE = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_EXHAUSTED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_ACCESS,
    JOB_REJECT
  } job_e;

  typedef struct packed {
    logic enabled;
    logic [COUNT_W-1:0] count;
    logic [PAGE_BYTES_W-1:0] page_bytes;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

  typedef struct packed {
    job_e job;
    logic [DESC_IW-1:0] index;
    logic [BASE_W-1:0] base;
    logic [PAGES_W-1:0] pages;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0] len;
    logic dir;
  } job_t;

endpackage

// File: hw/rtl/host_buffer_access_splitter.sv
// Top level of the host buffer access splitter: front end, job queue and walker.
//
//  channel | handshake               | beat
//  in      | in_valid_i / in_ready_o  | load descriptor or access request
//  out     | out_valid_o/out_ready_i | chunk or closing status
//  cfg     | cfg_we_i                | register write, no wait
//
// A load is written to the table from idle; a rejected access gets its status beat
// from idle. An accepted access walks at most count descriptors, fewer if its bytes
// run out early: the walker visits one descriptor a cycle unless the output stalls
// (table read and page multiply registered ahead of the overlap check), then closes
// with the status beat. A two-entry job queue lets new beats in while the walker
// runs; a stalled output holds it. Reset clears control state, not the table.
module host_buffer_access_splitter import hbas_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [CFG_DW-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [4:0]              entry_index_i,
  input  logic [BASE_W-1:0]       entry_base_i,
  input  logic [PAGES_W-1:0]      entry_pages_i,
  input  logic [OFFSET_W-1:0]     offset_i,
  input  logic [LEN_W-1:0]        length_i,
  input  logic                    is_write_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              kind_o,
  output logic [BASE_W-1:0]       phys_addr_o,
  output logic [LEN_W-1:0]        chunk_bytes_o,
  output logic                    write_dir_o,
  output logic                    last_o
);

  cfg_t cfg;
  job_t push_job, head_job;
  logic q_full, q_push, q_pop, q_valid;

  hbas_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_base_i  (entry_base_i),
    .entry_pages_i (entry_pages_i),
    .offset_i      (offset_i),
    .length_i      (length_i),
    .is_write_i    (is_write_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job),
    .cfg_o         (cfg)
  );

  hbas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  hbas_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_job_i       (head_job),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .phys_addr_o   (phys_addr_o),
    .chunk_bytes_o (chunk_bytes_o),
    .write_dir_o   (write_dir_o),
    .last_o        (last_o)
  );

endmodule

// File: hw/rtl/hbas_front.sv
// Front end: configuration registers, input beat acceptance and job classification.
module hbas_front import hbas_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [CFG_DW-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [4:0]              entry_index_i,
  input  logic [BASE_W-1:0]       entry_base_i,
  input  logic [PAGES_W-1:0]      entry_pages_i,
  input  logic [OFFSET_W-1:0]     offset_i,
  input  logic [LEN_W-1:0]        length_i,
  input  logic                    is_write_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output job_t                    q_job_o,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;
  logic [TOTAL_W-1:0] span;
  logic reject;
  logic index_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled <= 1'b0;
      cfg_q.count <= '0;
      cfg_q.page_bytes <= PAGE_BYTES_W'(4096);
      cfg_q.total <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLED: cfg_q.enabled <= cfg_wdata_i[0];
        CFG_COUNT: begin
          if (cfg_wdata_i[COUNT_W-1:0] > COUNT_W'(MAX_DESCRIPTORS)) begin
            cfg_q.count <= COUNT_W'(MAX_DESCRIPTORS);
          end else begin
            cfg_q.count <= cfg_wdata_i[COUNT_W-1:0];
          end
        end
        CFG_PAGE_BYTES: cfg_q.page_bytes <= cfg_wdata_i[PAGE_BYTES_W-1:0];
        CFG_TOTAL: cfg_q.total <= cfg_wdata_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign span = TOTAL_W'(offset_i) + TOTAL_W'(length_i);
  assign reject = !cfg_q.enabled || (cfg_q.count == '0) || (span > cfg_q.total);
  assign index_ok = 32'(entry_index_i) < MAX_DESCRIPTORS;

  assign in_ready_o = !q_full_i;
  // Out-of-range slot loads are dropped at the door.
  assign q_push_o = in_valid_i && in_ready_o && !(cmd_i == CMD_LOAD && !index_ok);

  always_comb begin
    q_job_o.job = JOB_ACCESS;
    if (cmd_i == CMD_LOAD) begin
      q_job_o.job = JOB_LOAD;
    end else if (reject) begin
      q_job_o.job = JOB_REJECT;
    end
    q_job_o.index = entry_index_i[DESC_IW-1:0];
    q_job_o.base = entry_base_i;
    q_job_o.pages = entry_pages_i;
    q_job_o.offset = offset_i;
    q_job_o.len = length_i;
    q_job_o.dir = is_write_i;
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/hbas_queue.sv
// Short job queue between the front end and the walker.
module hbas_queue import hbas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_q, rd_q;
  logic [QUEUE_PW:0] fill_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      fill_q <= fill_q + (QUEUE_PW+1)'(push_i) - (QUEUE_PW+1)'(pop_i);
    end
  end

  assign full_o = 32'(fill_q) == QUEUE_DEPTH;
  assign valid_o = fill_q != '0;
  assign job_o = mem_q[rd_q];

endmodule

// File: hw/rtl/hbas_back.sv
// Back end: descriptor table, segment walker and output register.
module hbas_back import hbas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              q_valid_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [BASE_W-1:0] phys_addr_o,
  output logic [LEN_W-1:0]  chunk_bytes_o,
  output logic              write_dir_o,
  output logic              last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  logic [BASE_W-1:0]  base_mem [MAX_DESCRIPTORS];
  logic [PAGES_W-1:0] pages_mem [MAX_DESCRIPTORS];

  state_e state_q;
  logic [COUNT_W-1:0] mi_q;
  logic m_valid_q;
  logic [SEG_W-1:0] seg_q;
  logic [BASE_W-1:0] base_q;
  logic [TOTAL_W-1:0] off_q, cur_q;
  logic [LEN_W-1:0] left_q;
  logic dir_q;
  kind_e fin_kind_q;

  logic out_valid_q;
  kind_e kind_q;
  logic [BASE_W-1:0] addr_q;
  logic [LEN_W-1:0] bytes_q;
  logic odir_q, last_q;

  logic adv;
  logic emit;
  logic [SEG_W:0] seg_end;
  logic skip, e_act, take;
  logic [TOTAL_W-1:0] in_seg;
  logic [SEG_W-1:0] avail;
  logic [LEN_W-1:0] xfer, left_after;
  logic finish;

  assign adv = !out_valid_q || out_ready_i;

  assign seg_end = (SEG_W+1)'(cur_q) + (SEG_W+1)'(seg_q);
  assign skip = (SEG_W+1)'(off_q) >= seg_end;
  assign in_seg = off_q - cur_q;
  assign avail = seg_q - SEG_W'(in_seg);
  assign xfer = (SEG_W'(left_q) < avail) ? left_q : avail[LEN_W-1:0];
  assign e_act = m_valid_q && (left_q != '0);
  assign take = e_act && !skip;
  assign left_after = take ? left_q - xfer : left_q;
  assign finish = (left_after == '0) || (m_valid_q && mi_q == cfg_i.count);

  always_comb begin
    q_pop_o = 1'b0;
    if (state_q == ST_IDLE && q_valid_i) begin
      q_pop_o = (q_job_i.job != JOB_REJECT) || adv;
    end
  end

  // output register loads a new beat this cycle
  assign emit = (state_q == ST_IDLE && q_pop_o && q_job_i.job == JOB_REJECT) ||
                (state_q == ST_WALK && adv && take) ||
                (state_q == ST_FIN && adv);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i && q_job_i.job == JOB_LOAD) begin
      base_mem[q_job_i.index] <= q_job_i.base;
      pages_mem[q_job_i.index] <= q_job_i.pages;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mi_q <= '0;
      m_valid_q <= 1'b0;
      seg_q <= '0;
      base_q <= '0;
      off_q <= '0;
      cur_q <= '0;
      left_q <= '0;
      dir_q <= 1'b0;
      out_valid_q <= 1'b0;
      fin_kind_q <= KIND_DONE;
      kind_q <= KIND_DONE;
      addr_q <= '0;
      bytes_q <= '0;
      odir_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            dir_q <= q_job_i.dir;
            case (q_job_i.job)
              JOB_REJECT: begin
                kind_q <= KIND_REJECT;
                addr_q <= '0;
                bytes_q <= '0;
                odir_q <= q_job_i.dir;
                last_q <= 1'b1;
              end
              JOB_ACCESS: begin
                off_q <= TOTAL_W'(q_job_i.offset);
                left_q <= q_job_i.len;
                cur_q <= '0;
                mi_q <= '0;
                m_valid_q <= 1'b0;
                state_q <= ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (adv) begin
            if (take) begin
              kind_q <= KIND_CHUNK;
              addr_q <= base_q + BASE_W'(in_seg);
              bytes_q <= xfer;
              odir_q <= dir_q;
              last_q <= 1'b0;
              off_q <= off_q + TOTAL_W'(xfer);
              left_q <= left_after;
              cur_q <= seg_end[TOTAL_W-1:0];
            end else if (e_act) begin
              cur_q <= seg_end[TOTAL_W-1:0];
            end
            if (finish) begin
              m_valid_q <= 1'b0;
              fin_kind_q <= (left_after == '0) ? KIND_DONE : KIND_EXHAUSTED;
              state_q <= ST_FIN;
            end else if (mi_q < cfg_i.count) begin
              m_valid_q <= 1'b1;
              seg_q <= SEG_W'(pages_mem[mi_q[DESC_IW-1:0]]) * SEG_W'(cfg_i.page_bytes);
              base_q <= base_mem[mi_q[DESC_IW-1:0]];
              mi_q <= mi_q + 1'b1;
            end else begin
              m_valid_q <= 1'b0;
            end
          end
        end
        ST_FIN: begin
          if (adv) begin
            kind_q <= fin_kind_q;
            addr_q <= '0;
            bytes_q <= '0;
            odir_q <= dir_q;
            last_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign phys_addr_o = addr_q;
  assign chunk_bytes_o = bytes_q;
  assign write_dir_o = odir_q;
  assign last_o = last_q;

endmodule

// File: hw/rtl/hbas_checker.sv
// Port-level checker for the host buffer access splitter, bound to the top level.
`include "host_buffer_access_splitter_assert.svh"

module hbas_checker import hbas_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        kind_o,
  input logic [BASE_W-1:0] phys_addr_o,
  input logic [LEN_W-1:0]  chunk_bytes_o,
  input logic              write_dir_o,
  input logic              last_o
);

  `HBAS_ASSERT(a_chunk_shape,
    out_valid_o && kind_o == KIND_CHUNK |-> !last_o && chunk_bytes_o != '0,
    "chunk beat marked last or empty")
  `HBAS_ASSERT(a_status_shape,
    out_valid_o && kind_o != KIND_CHUNK |->
      last_o && chunk_bytes_o == '0 && phys_addr_o == '0,
    "status beat carries data")
  `HBAS_ASSERT(a_no_reject_after_chunk,
    out_valid_o && out_ready_i && kind_o == KIND_CHUNK |=>
      !(out_valid_o && kind_o == KIND_REJECT),
    "reject inside an access")
  `HBAS_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(phys_addr_o) && $stable(chunk_bytes_o) && $stable(write_dir_o),
    "output beat changed under stall")
  `HBAS_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind host_buffer_access_splitter hbas_checker u_hbas_checker (.*);

// File: tb/sv/host_buffer_access_splitter_test.sv
// Self-checking bench for the host buffer access splitter: directed table, then random beats.
module host_buffer_access_splitter_test;
  import hbas_pkg::*;

  localparam logic CMD_XLATE = 1'b1;
  localparam int DRAIN = 48;
  localparam int HOLD_LEN = 300;
  localparam int WATCHDOG = 3000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 25;
  localparam int PLAN_LEN = 29;
  localparam logic [63:0] SPAN_CAP = 64'd1 << 48;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_ACCESS,
    ROW_FILL
  } row_e;

  // cfg: a enabled, b count, c page bytes, d total
  // load: a slot, b base, c pages
  // access: a offset, b length, c direction
  typedef struct packed {
    row_e op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic pinned;
    kind_e want;
  } row_t;

  typedef struct packed {
    logic cmd;
    logic [4:0] idx;
    logic [63:0] base;
    logic [31:0] pages;
    logic [47:0] off;
    logic [31:0] len;
    logic wr;
  } req_t;

  typedef struct packed {
    kind_e kind;
    logic [63:0] addr;
    logic [31:0] bytes;
    logic dir;
    logic last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic cmd_i;
  logic [4:0] entry_index_i;
  logic [BASE_W-1:0] entry_base_i;
  logic [PAGES_W-1:0] entry_pages_i;
  logic [OFFSET_W-1:0] offset_i;
  logic [LEN_W-1:0] length_i;
  logic is_write_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [1:0] kind_o;
  logic [BASE_W-1:0] phys_addr_o;
  logic [LEN_W-1:0] chunk_bytes_o;
  logic write_dir_o;
  logic last_o;

  // shadow of the block's registers and descriptor table
  logic buf_en;
  logic [COUNT_W-1:0] desc_cnt;
  logic [PAGE_BYTES_W-1:0] pg_bytes;
  logic [TOTAL_W-1:0] tot_bytes;
  logic [BASE_W-1:0] seg_base [MAX_DESCRIPTORS];
  logic [PAGES_W-1:0] seg_pages [MAX_DESCRIPTORS];

  beat_t beats_due[$];
  int errors = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic hold_req = 1'b0;
  logic calm = 1'b0;

  row_t plan [PLAN_LEN] = '{
    '{ROW_ACCESS, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, KIND_REJECT},
    '{ROW_FILL, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, KIND_DONE},
    '{ROW_LOAD, 64'd0, 64'h0000_0000_1000_0000, 64'd2, 64'd0, 1'b0, KIND_DONE},
    '{ROW_LOAD, 64'd1, 64'hDEAD_BEEF_0000_0000, 64'd0, 64'd0, 1'b0, KIND_DONE},
    '{ROW_LOAD, 64'd2, 64'hFFFF_FFFF_FFFF_F000, 64'd3, 64'd0, 1'b0, KIND_DONE},
    '{ROW_LOAD, 64'd3, 64'd0, 64'd1, 64'd0, 1'b0, KIND_DONE},
    '{ROW_CFG, 64'd1, 64'd4, 64'd4096, 64'd32768, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd0, 64'd24576, 64'd1, 64'd0, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd4096, 64'd8192, 64'd0, 64'd0, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd10000, 64'd14576, 64'd1, 64'd0, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd20000, 64'd8000, 64'd0, 64'd0, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd24576, 64'd100, 64'd1, 64'd0, 1'b1, KIND_EXHAUSTED},
    '{ROW_ACCESS, 64'd0, 64'd0, 64'd1, 64'd0, 1'b1, KIND_DONE},
    '{ROW_ACCESS, 64'd32000, 64'd769, 64'd0, 64'd0, 1'b1, KIND_REJECT},
    '{ROW_ACCESS, 64'd32768, 64'd0, 64'd0, 64'd0, 1'b1, KIND_DONE},
    '{ROW_CFG, 64'd1, 64'd0, 64'd4096, 64'd32768, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd0, 64'd1, 64'd1, 64'd0, 1'b1, KIND_REJECT},
    '{ROW_CFG, 64'd0, 64'd4, 64'd4096, 64'd32768, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd0, 64'd1, 64'd0, 64'd0, 1'b1, KIND_REJECT},
    '{ROW_CFG, 64'd1, 64'd63, 64'd0, SPAN_CAP, 1'b0, KIND_DONE},
    '{ROW_ACCESS, SPAN_CAP - 1, 64'd1, 64'd1, 64'd0, 1'b1, KIND_EXHAUSTED},
    '{ROW_LOAD, 64'd0, {64{1'b1}}, 64'hFFFF_FFFF, 64'd0, 1'b0, KIND_DONE},
    '{ROW_CFG, 64'd1, 64'd63, 64'd1 << 27, SPAN_CAP, 1'b0, KIND_DONE},
    '{ROW_ACCESS, SPAN_CAP - 1, 64'd1, 64'd1, 64'd0, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd0, 64'hFFFF_FFFF, 64'd0, 64'd0, 1'b0, KIND_DONE},
    '{ROW_ACCESS, SPAN_CAP - 1, 64'hFFFF_FFFF, 64'd1, 64'd0, 1'b1, KIND_REJECT},
    '{ROW_LOAD, 64'd0, 64'd0, 64'd1, 64'd0, 1'b0, KIND_DONE},
    '{ROW_CFG, 64'd1, 64'd33, 64'd4096, 64'd1 << 21, 1'b0, KIND_DONE},
    '{ROW_ACCESS, 64'd0, 64'd1 << 21, 64'd0, 64'd0, 1'b0, KIND_DONE}
  };

  host_buffer_access_splitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_base_i  (entry_base_i),
    .entry_pages_i (entry_pages_i),
    .offset_i      (offset_i),
    .length_i      (length_i),
    .is_write_i    (is_write_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .phys_addr_o   (phys_addr_o),
    .chunk_bytes_o (chunk_bytes_o),
    .write_dir_o   (write_dir_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.cmd = 1'($urandom);
    r.idx = 5'($urandom);
    r.base = {$urandom, $urandom};
    r.pages = $urandom;
    r.off = 48'({$urandom, $urandom});
    r.len = $urandom;
    r.wr = 1'($urandom);
    return r;
  endfunction

  function automatic void expect_status(kind_e k, logic dir);
    beats_due.push_back('{k, 64'd0, 32'd0, dir, 1'b1});
  endfunction

  // walks the descriptor table and queues the chunks and closing status
  function automatic void translate_access(logic [47:0] off_in, logic [31:0] len_in,
                                           logic dir);
    logic [63:0] off, left, cur, seg, in_seg, avail, xfer;
    int walk;
    off = {16'd0, off_in};
    left = {32'd0, len_in};
    if (!buf_en || desc_cnt == 0 || off + left > {15'd0, tot_bytes}) begin
      expect_status(KIND_REJECT, dir);
      return;
    end
    walk = (desc_cnt > MAX_DESCRIPTORS) ? MAX_DESCRIPTORS : desc_cnt;
    cur = 64'd0;
    for (int i = 0; i < walk && left != 0; i++) begin
      seg = {32'd0, seg_pages[i]} * {36'd0, pg_bytes};
      if (off >= cur + seg) begin
        cur += seg;
      end else begin
        in_seg = off - cur;
        avail = seg - in_seg;
        xfer = (left < avail) ? left : avail;
        beats_due.push_back('{KIND_CHUNK, seg_base[i] + in_seg, xfer[31:0], dir, 1'b0});
        off += xfer;
        left -= xfer;
        cur += seg;
      end
    end
    expect_status((left == 0) ? KIND_DONE : KIND_EXHAUSTED, dir);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // lower valid, let every due beat arrive, then let trailing loads retire
  task automatic settle();
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic program_regs(logic en, logic [5:0] cnt, logic [27:0] pgb, logic [48:0] tot);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ENABLED;
    cfg_wdata_i <= {48'd0, en};
    @(negedge clk_i);
    cfg_idx_i <= CFG_COUNT;
    cfg_wdata_i <= {43'd0, cnt};
    @(negedge clk_i);
    cfg_idx_i <= CFG_PAGE_BYTES;
    cfg_wdata_i <= {21'd0, pgb};
    @(negedge clk_i);
    cfg_idx_i <= CFG_TOTAL;
    cfg_wdata_i <= tot;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    buf_en = en;
    desc_cnt = cnt;
    pg_bytes = pgb;
    tot_bytes = tot;
  endtask

  task automatic offer(req_t r, int gap, logic pinned, kind_e want);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= r.cmd;
    entry_index_i <= r.idx;
    entry_base_i <= r.base;
    entry_pages_i <= r.pages;
    offset_i <= r.off;
    length_i <= r.len;
    is_write_i <= r.wr;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.cmd == CMD_LOAD) begin
      seg_base[r.idx] = r.base;
      seg_pages[r.idx] = r.pages;
    end else if (pinned) begin
      expect_status(want, r.wr);
    end else begin
      translate_access(r.off, r.len, r.wr);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_LEN;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    beat_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $display("%0t: beat with nothing due, expected none actual kind %0d addr %h",
                 $time, kind_o, phys_addr_o);
        errors++;
      end else begin
        due = beats_due.pop_front();
        check_field("kind", 64'(due.kind), 64'(kind_o));
        check_field("phys_addr", due.addr, phys_addr_o);
        check_field("chunk_bytes", 64'(due.bytes), 64'(chunk_bytes_o));
        check_field("write_dir", 64'(due.dir), 64'(write_dir_o));
        check_field("last", 64'(due.last), 64'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
      $display("host_buffer_access_splitter: mismatch");
      $finish;
    end
  end

  initial begin
    req_t r;
    logic en_v;
    logic [5:0] cnt_v;
    logic [27:0] pgb_v;
    logic [63:0] span, tot_v, off_v, room, len_v;
    int walk;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ENABLED;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_LOAD;
    entry_index_i = '0;
    entry_base_i = '0;
    entry_pages_i = '0;
    offset_i = '0;
    length_i = '0;
    is_write_i = 1'b0;
    out_ready_i = 1'b0;
    buf_en = 1'b0;
    desc_cnt = '0;
    pg_bytes = 28'd4096;
    tot_bytes = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      r = noise_req();
      case (plan[k].op)
        ROW_CFG: begin
          program_regs(plan[k].a[0], plan[k].b[5:0], plan[k].c[27:0], plan[k].d[48:0]);
        end
        ROW_FILL: begin
          for (int s = 0; s < MAX_DESCRIPTORS; s++) begin
            r = noise_req();
            r.cmd = CMD_LOAD;
            r.idx = 5'(s);
            r.pages = $urandom_range(1, 8);
            offer(r, idle_len(), 1'b0, KIND_DONE);
          end
        end
        ROW_LOAD: begin
          r.cmd = CMD_LOAD;
          r.idx = plan[k].a[4:0];
          r.base = plan[k].b;
          r.pages = plan[k].c[31:0];
          offer(r, idle_len(), 1'b0, KIND_DONE);
        end
        default: begin
          r.cmd = CMD_XLATE;
          r.off = plan[k].a[47:0];
          r.len = plan[k].b[31:0];
          r.wr = plan[k].c[0];
          offer(r, idle_len(), plan[k].pinned, plan[k].want);
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      en_v = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
        0: cnt_v = 6'd1;
        1: cnt_v = 6'd32;
        2: cnt_v = 6'd63;
        3: cnt_v = 6'($urandom_range(33, 62));
        default: cnt_v = 6'($urandom_range(2, 31));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pgb_v = 28'd4096;
        4, 5: pgb_v = 28'd1 << 27;
        6, 7: pgb_v = 28'($urandom_range(4096, 65536));
        8: pgb_v = 28'($urandom_range(4096, 28'hFFF_FFFF));
        default: pgb_v = 28'($urandom_range(0, 4095));
      endcase
      walk = (cnt_v > MAX_DESCRIPTORS) ? MAX_DESCRIPTORS : cnt_v;
      span = 64'd0;
      for (int s = 0; s < walk; s++) begin
        span += {32'd0, seg_pages[s]} * {36'd0, pgb_v};
        if (span > SPAN_CAP) span = SPAN_CAP;
      end
      case ($urandom_range(0, 7))
        0: tot_v = SPAN_CAP;
        1: tot_v = {$urandom, $urandom} % (span + 1);
        2: tot_v = span + $urandom_range(1, 100000);
        default: tot_v = span;
      endcase
      if (tot_v > SPAN_CAP) tot_v = SPAN_CAP;
      program_regs(en_v, cnt_v, pgb_v, tot_v[48:0]);
      calm = (ph % 4 == 3);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // receiver holds off while the sender keeps offering
        if (ph == 1 && n == 6) hold_req = 1'b1;
        // sender pauses until every due beat is back
        if (ph == 2 && n == 15) settle();
        r = noise_req();
        case ($urandom_range(0, 9))
          0, 1: begin
            r.cmd = CMD_LOAD;
            case ($urandom_range(0, 9))
              0, 1: r.pages = 32'd0;
              2, 3: r.pages = $urandom;
              4: r.pages = $urandom_range(17, 4096);
              default: r.pages = $urandom_range(1, 16);
            endcase
          end
          2, 3: r.cmd = CMD_XLATE;
          default: begin
            r.cmd = CMD_XLATE;
            off_v = (tot_bytes != 0) ? {$urandom, $urandom} % {15'd0, tot_bytes} : 64'd0;
            room = {15'd0, tot_bytes} - off_v;
            if (room > 64'hFFFF_FFFF) room = 64'hFFFF_FFFF;
            case ($urandom_range(0, 7))
              0: len_v = 64'd0;
              1: len_v = room;
              2: len_v = $urandom_range(1, 8192) % (room + 1);
              default: len_v = {$urandom, $urandom} % (room + 1);
            endcase
            r.off = off_v[47:0];
            r.len = len_v[31:0];
          end
        endcase
        offer(r, calm ? 0 : idle_len(), 1'b0, KIND_DONE);
      end
    end

    settle();
    if (errors == 0)
      $display("host_buffer_access_splitter: match");
    else
      $display("host_buffer_access_splitter: mismatch");
    $finish;
  end

endmodule
